/* hw/rtl/bfsc_pkg.sv */
// Shared types and constants for the compressed-adjacency BFS block.
// Used by the controller, the datapath and the top level; depends on nothing.
package bfsc_pkg;

	localparam logic [1:0] ACT_ROW    = 2'd0;
	localparam logic [1:0] ACT_EDGE   = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_VERTEX   = 2'd1;
	localparam logic [1:0] ST_NEIGHBOR = 2'd2;
	localparam logic [1:0] ST_ADDRESS  = 2'd3;

	localparam logic [10:0] VCOUNT_RESET = 11'd1024;
	localparam logic [2:0]  VARINT_LAST  = 3'd4;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TAKE,
		OP_CLEAR,
		OP_INIT,
		OP_DEQ,
		OP_LOADV,
		OP_LOADR,
		OP_BYTE,
		OP_GAP,
		OP_CHECK,
		OP_VISIT,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		EM_WRITE,
		EM_BADV,
		EM_READ,
		EM_SEARCH
	} src_t;

	typedef struct packed {
		op_t  op;
		logic emit;
		src_t src;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       out_free;
		logic       vtx_bad;
		logic       clr_last;
		logic       que_empty;
		logic       row_done;
		logic       gap_done;
		logic       skip;
	} sts_t;

endpackage

/* hw/rtl/bfsc_req_if.sv */
// Request channel: valid/ready handshake with one action beat.
// Depends on nothing.
interface bfsc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [12:0] address;
	logic [13:0] value;
	logic [9:0]  vertex;

	modport source(output valid, output action, output address, output value,
		output vertex, input ready);
	modport sink(input valid, input action, input address, input value,
		input vertex, output ready);
endinterface

/* hw/rtl/bfsc_rsp_if.sv */
// Response channel: valid/ready handshake with one result beat.
// Depends on nothing.
interface bfsc_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [10:0]        reached_count;
	logic signed [10:0] distance;
	logic [9:0]         parent_vertex;
	logic               has_parent;

	modport source(output valid, output status, output reached_count, output distance,
		output parent_vertex, output has_parent, input ready);
	modport sink(input valid, input status, input reached_count, input distance,
		input parent_vertex, input has_parent, output ready);
endinterface

/* hw/rtl/bfs_compressed_adjacency.sv */
// Breadth-first search over a varint gap-compressed adjacency store.
// Top level; depends on bfsc_pkg, bfsc_req_if, bfsc_rsp_if, bfsc_ctl and bfsc_dp.
//
// Usage: req carries one action beat (write row start, write edge byte, search,
// read vertex) and rsp returns exactly one result beat for each of them.
// cfg_we/cfg_wdata set the vertex count; the user must write them only while
// idle, which the block does not enforce. Row and edge writes have their
// result beat registered in the same cycle that the request is taken. A read
// emits its beat from the registered read of the distance and parent memories.
// A search first clears the distance table with a sweep over all MAX_VERTICES
// entries, then dequeues each reached vertex, loads its row bounds and decodes
// its edge bytes; the controller loop and the single edge memory port set its
// pace, and one item is worked on at a time.
// After reset the vertex count is 1024, the reached count is zero and every
// vertex reads as unreached; no memory clearing pass runs at reset.
// The response register holds a finished beat while rsp.ready is low; a new
// request is taken once that register is free or being emptied.
module bfs_compressed_adjacency
	import bfsc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int EDGE_BYTES   = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	bfsc_req_if.sink    req,
	bfsc_rsp_if.source  rsp
);

	cmd_t cmd;
	sts_t sts;

	bfsc_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfsc_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.EDGE_BYTES   (EDGE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.action    (req.action),
		.address   (req.address),
		.value     (req.value),
		.vertex    (req.vertex),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

/* hw/rtl/bfsc_dp.sv */
// Datapath: adjacency, distance, parent and queue memories, varint decoder,
// and the response register. Depends on bfsc_pkg and bfsc_rsp_if.
module bfsc_dp
	import bfsc_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int EDGE_BYTES   = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	input  logic [1:0]  action,
	input  logic [12:0] address,
	input  logic [13:0] value,
	input  logic [9:0]  vertex,
	input  cmd_t        cmd,
	output sts_t        sts,
	bfsc_rsp_if.source  rsp
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DW = CW + 1;
	localparam int EW = $clog2(EDGE_BYTES);
	localparam int PW = $clog2(EDGE_BYTES + 1);

	logic [13:0]   row_mem [0:MAX_VERTICES];
	logic [7:0]    edge_mem [0:EDGE_BYTES-1];
	logic [DW-1:0] dist_mem [0:MAX_VERTICES-1];
	logic [VW-1:0] par_mem [0:MAX_VERTICES-1];
	logic [VW-1:0] que_mem [0:MAX_VERTICES-1];

	logic [13:0]   row_rd0, row_rd1;
	logic [7:0]    edge_rd;
	logic [DW-1:0] dist_rd;
	logic [VW-1:0] par_rd, que_rd;

	logic [10:0]   vcount_q;
	logic          ran_q, stat_q, over_q;
	logic [VW-1:0] src_q, clr_q, v_q;
	logic [CW-1:0] head_q, tail_q, reached_q, id_q;
	logic [DW-1:0] vdist_q;
	logic [PW-1:0] pos_q, end_q;
	logic [34:0]   gap_q;
	logic [2:0]    k_q;

	logic          out_valid_q, has_parent_q;
	logic [1:0]    status_q;
	logic [10:0]   reached_out_q, distance_q;
	logic [9:0]    parent_q;

	logic [CW-1:0] n;
	logic          row_bad, edge_bad, vtx_bad, wr_row, wr_edge, fresh, skip, gap_done;
	logic          dist_we, dist_re, que_we, par_we;
	logic [VW-1:0] dist_wa, dist_ra, que_wa, que_wd;
	logic [DW-1:0] dist_wd;
	logic [34:0]   gap_new;
	logic [CW:0]   id_sum;
	logic [1:0]    e_status;
	logic [10:0]   e_reached, e_distance;
	logic [9:0]    e_parent;
	logic          e_hasp;
	logic [DW-1:0] rd_dist;

	function automatic logic [PW-1:0] lim_pos(input logic [13:0] p);
		if (32'(p) > 32'(EDGE_BYTES))
			return PW'(EDGE_BYTES);
		return PW'(p);
	endfunction

	always_comb begin
		n = (32'(vcount_q) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_q);
		row_bad  = 32'(address) > 32'(n);
		edge_bad = 32'(address) >= 32'(EDGE_BYTES);
		vtx_bad  = 32'(vertex) >= 32'(n);
		wr_row   = (cmd.op == OP_TAKE) && (action == ACT_ROW) && !row_bad;
		wr_edge  = (cmd.op == OP_TAKE) && (action == ACT_EDGE) && !edge_bad;
		fresh    = &dist_rd;
		skip     = over_q || (id_q >= n);
		gap_new  = gap_q | (35'(edge_rd[6:0]) << (6'd7 * 6'(k_q)));
		gap_done = !edge_rd[7] || (k_q == VARINT_LAST) || (pos_q >= end_q);
		id_sum   = (CW + 1)'(id_q) + (CW + 1)'(gap_new[CW-1:0]);
	end

	always_comb begin
		dist_we = 1'b0;
		dist_wa = clr_q;
		dist_wd = '1;
		dist_re = 1'b0;
		dist_ra = VW'(vertex);
		que_we  = 1'b0;
		que_wa  = '0;
		que_wd  = src_q;
		par_we  = 1'b0;
		case (cmd.op)
			OP_TAKE: begin
				dist_re = 1'b1;
			end
			OP_CLEAR: begin
				dist_we = 1'b1;
			end
			OP_INIT: begin
				dist_we = 1'b1;
				dist_wa = src_q;
				dist_wd = '0;
				que_we  = 1'b1;
			end
			OP_LOADV: begin
				dist_re = 1'b1;
				dist_ra = que_rd;
			end
			OP_CHECK: begin
				dist_re = !skip;
				dist_ra = VW'(id_q);
			end
			OP_VISIT: begin
				dist_we = fresh;
				dist_wa = VW'(id_q);
				dist_wd = vdist_q + DW'(1);
				par_we  = fresh;
				que_we  = fresh && (tail_q < CW'(MAX_VERTICES));
				que_wa  = VW'(tail_q);
				que_wd  = VW'(id_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_row)
			row_mem[CW'(address)] <= value;
		if (wr_edge)
			edge_mem[EW'(address)] <= value[7:0];
		if (cmd.op == OP_LOADV) begin
			row_rd0 <= row_mem[CW'(que_rd)];
			row_rd1 <= row_mem[CW'(que_rd) + CW'(1)];
		end
		if (cmd.op == OP_BYTE)
			edge_rd <= edge_mem[EW'(pos_q)];
		if (dist_we)
			dist_mem[dist_wa] <= dist_wd;
		if (dist_re)
			dist_rd <= dist_mem[dist_ra];
		if (par_we)
			par_mem[VW'(id_q)] <= v_q;
		if (cmd.op == OP_TAKE)
			par_rd <= par_mem[VW'(vertex)];
		if (que_we)
			que_mem[que_wa] <= que_wd;
		if (cmd.op == OP_DEQ)
			que_rd <= que_mem[VW'(head_q)];
	end

	always_comb begin
		rd_dist    = ran_q ? dist_rd : '1;
		e_status   = ST_OK;
		e_reached  = 11'(reached_q);
		e_distance = '0;
		e_parent   = '0;
		e_hasp     = 1'b0;
		case (cmd.src)
			EM_WRITE: begin
				if ((action == ACT_ROW) ? row_bad : edge_bad)
					e_status = ST_ADDRESS;
			end
			EM_BADV: begin
				e_status = ST_VERTEX;
				if (action == ACT_READ)
					e_distance = '1;
			end
			EM_READ: begin
				e_distance = 11'($signed(rd_dist));
				e_hasp     = !rd_dist[DW-1] && (rd_dist != '0);
				if (e_hasp)
					e_parent = 10'(par_rd);
			end
			EM_SEARCH: begin
				e_status  = stat_q ? ST_NEIGHBOR : ST_OK;
				e_reached = 11'(tail_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q      <= VCOUNT_RESET;
			ran_q         <= 1'b0;
			stat_q        <= 1'b0;
			over_q        <= 1'b0;
			src_q         <= '0;
			clr_q         <= '0;
			v_q           <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			reached_q     <= '0;
			id_q          <= '0;
			vdist_q       <= '0;
			pos_q         <= '0;
			end_q         <= '0;
			gap_q         <= '0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_OK;
			reached_out_q <= '0;
			distance_q    <= '0;
			parent_q      <= '0;
			has_parent_q  <= 1'b0;
		end else begin
			if (cfg_we)
				vcount_q <= cfg_wdata;
			case (cmd.op)
				OP_TAKE: begin
					src_q <= VW'(vertex);
					clr_q <= '0;
				end
				OP_CLEAR: begin
					clr_q <= clr_q + VW'(1);
				end
				OP_INIT: begin
					head_q <= '0;
					tail_q <= CW'(1);
					stat_q <= 1'b0;
					ran_q  <= 1'b1;
				end
				OP_DEQ: begin
					head_q <= head_q + CW'(1);
				end
				OP_LOADV: begin
					v_q <= que_rd;
				end
				OP_LOADR: begin
					pos_q   <= lim_pos(row_rd0);
					end_q   <= lim_pos(row_rd1);
					vdist_q <= dist_rd;
					id_q    <= '0;
					over_q  <= 1'b0;
					gap_q   <= '0;
					k_q     <= '0;
				end
				OP_BYTE: begin
					pos_q <= pos_q + PW'(1);
				end
				OP_GAP: begin
					if (gap_done) begin
						id_q   <= id_sum[CW-1:0];
						over_q <= over_q || id_sum[CW] || ((gap_new >> CW) != '0);
						gap_q  <= '0;
						k_q    <= '0;
					end else begin
						gap_q <= gap_new;
						k_q   <= k_q + 3'd1;
					end
				end
				OP_CHECK: begin
					if (skip)
						stat_q <= 1'b1;
				end
				OP_VISIT: begin
					if (fresh && (tail_q < CW'(MAX_VERTICES)))
						tail_q <= tail_q + CW'(1);
				end
				OP_FINISH: begin
					reached_q <= tail_q;
				end
				default: begin
				end
			endcase
			if (cmd.emit) begin
				out_valid_q   <= 1'b1;
				status_q      <= e_status;
				reached_out_q <= e_reached;
				distance_q    <= e_distance;
				parent_q      <= e_parent;
				has_parent_q  <= e_hasp;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.action    = action;
		sts.out_free  = !out_valid_q || rsp.ready;
		sts.vtx_bad   = vtx_bad;
		sts.clr_last  = (clr_q == VW'(MAX_VERTICES - 1));
		sts.que_empty = (head_q == tail_q);
		sts.row_done  = (pos_q >= end_q);
		sts.gap_done  = gap_done;
		sts.skip      = skip;
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.reached_count = reached_out_q;
	assign rsp.distance      = $signed(distance_q);
	assign rsp.parent_vertex = parent_q;
	assign rsp.has_parent    = has_parent_q;

endmodule

/* hw/rtl/bfsc_ctl.sv */
// Controller: one-hot state machine that sequences loads, reads and the search.
// Depends on bfsc_pkg; drives the datapath through cmd_t and watches sts_t.
module bfsc_ctl
	import bfsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_READ  = 12'b000000000010,
		S_CLEAR = 12'b000000000100,
		S_INIT  = 12'b000000001000,
		S_DEQ   = 12'b000000010000,
		S_LOADV = 12'b000000100000,
		S_LOADR = 12'b000001000000,
		S_BYTE  = 12'b000010000000,
		S_GAP   = 12'b000100000000,
		S_CHECK = 12'b001000000000,
		S_VISIT = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		req_ready = 1'b0;
		cmd.op    = OP_NONE;
		cmd.emit  = 1'b0;
		cmd.src   = EM_WRITE;
		case (state_q)
			S_IDLE: begin
				req_ready = sts.out_free;
				if (req_valid && sts.out_free) begin
					cmd.op = OP_TAKE;
					case (sts.action)
						ACT_ROW, ACT_EDGE: begin
							cmd.emit = 1'b1;
						end
						ACT_SEARCH: begin
							if (sts.vtx_bad) begin
								cmd.emit = 1'b1;
								cmd.src  = EM_BADV;
							end else begin
								state_nxt = S_CLEAR;
							end
						end
						ACT_READ: begin
							if (sts.vtx_bad) begin
								cmd.emit = 1'b1;
								cmd.src  = EM_BADV;
							end else begin
								state_nxt = S_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.src   = EM_READ;
					state_nxt = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_last)
					state_nxt = S_INIT;
			end
			S_INIT: begin
				cmd.op    = OP_INIT;
				state_nxt = S_DEQ;
			end
			S_DEQ: begin
				if (sts.que_empty) begin
					state_nxt = S_DONE;
				end else begin
					cmd.op    = OP_DEQ;
					state_nxt = S_LOADV;
				end
			end
			S_LOADV: begin
				cmd.op    = OP_LOADV;
				state_nxt = S_LOADR;
			end
			S_LOADR: begin
				cmd.op    = OP_LOADR;
				state_nxt = S_BYTE;
			end
			S_BYTE: begin
				if (sts.row_done) begin
					state_nxt = S_DEQ;
				end else begin
					cmd.op    = OP_BYTE;
					state_nxt = S_GAP;
				end
			end
			S_GAP: begin
				cmd.op    = OP_GAP;
				state_nxt = sts.gap_done ? S_CHECK : S_BYTE;
			end
			S_CHECK: begin
				cmd.op    = OP_CHECK;
				state_nxt = sts.skip ? S_BYTE : S_VISIT;
			end
			S_VISIT: begin
				cmd.op    = OP_VISIT;
				state_nxt = S_BYTE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.op    = OP_FINISH;
					cmd.emit  = 1'b1;
					cmd.src   = EM_SEARCH;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
